// ===== rtl/dusa_pkg.sv =====
// Shared types for the DMX universe source arbiter: request, result and state codes.
package dusa_pkg;

  // Width of the configuration register.
  localparam int unsigned TIMEOUT_W = 32;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd2500;

  // One channel request.
  typedef struct packed {
    logic [3:0]  universe;
    logic [7:0]  channel_value;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [2:0]  source_id;
    logic [7:0]  priority_req;
    logic [31:0] now_ticks;
  } dusa_in_t;

  // One channel result.
  typedef struct packed {
    logic        accepted;
    logic [3:0]  out_universe;
    logic [8:0]  channel_index;
    logic [7:0]  old_value;
    logic [7:0]  new_value;
    logic        frame_end;
  } dusa_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } dusa_state_t;

endpackage

// ===== rtl/dmx_universe_source_arbiter.sv =====
// Top level of the DMX universe source arbiter: frame arbitration and channel store.
//
//   channel   ports                            direction  handshake
//   request   start, busy, in_item             in         taken when start && !busy
//   result    out_strobe, out_result           out        one cycle, no back-pressure
//   config    cfg_we, cfg_wdata                in         written when cfg_we
//
// Every request runs in its accept cycle and its execute cycle: the accept cycle issues reads of the universe
// table and the channel store, the next cycle arbitrates (on a first item),
// writes both memories back and registers the result. The registered read
// data of the two RAMs is why the work is split so; a new request is taken only
// once busy has fallen, and its result shows in the cycle after the execute cycle, as busy falls.
// Reset clears the control state and the valid bits of the universe table at
// once; the channel store needs no clearing pass since a per-universe fill
// count marks which channels were ever written. The receiver cannot stall.
module dmx_universe_source_arbiter #(
  parameter int NUM_UNIVERSES         = 16,
  parameter int CHANNELS_PER_UNIVERSE = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  dusa_pkg::dusa_in_t              in_item,
  output logic                            out_strobe,
  output dusa_pkg::dusa_out_t             out_result,
  input  logic                            cfg_we,
  input  logic [dusa_pkg::TIMEOUT_W-1:0]  cfg_wdata
);

  localparam int UIDX_W   = (NUM_UNIVERSES > 1) ? $clog2(NUM_UNIVERSES) : 1;
  localparam int CNT_W    = $clog2(CHANNELS_PER_UNIVERSE + 1);
  localparam int CH_DEPTH = NUM_UNIVERSES * CHANNELS_PER_UNIVERSE;
  localparam int CADDR_W  = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;
  // Table entry: owner source, owner priority, last update time, fill count.
  // A universe is primed exactly when its fill count is nonzero.
  localparam int ENT_W    = 3 + 8 + 32 + CNT_W;

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  dusa_pkg::dusa_state_t state_r, state_nxt;

  logic [dusa_pkg::TIMEOUT_W-1:0] timeout_r;

  dusa_pkg::dusa_in_t req_r;           // request under work
  logic [CADDR_W-1:0] ch_addr_r;       // channel store address of this request
  logic               tbl_vld_r;       // table entry was ever written
  logic               in_range_r;      // request universe below NUM_UNIVERSES

  // Open frame
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             taken_r, taken_nxt;
  logic [3:0]       univ_r, univ_nxt;
  logic [2:0]       own_src_r;
  logic [7:0]       own_prio_r;
  logic [31:0]      own_time_r;
  logic [CNT_W-1:0] fill_r;

  logic valid_r [NUM_UNIVERSES];

  logic                out_strobe_r;
  dusa_pkg::dusa_out_t out_result_r;

  // ---------------------------------------------------------------------
  // Accept side: pick the frame position and issue the memory reads
  // ---------------------------------------------------------------------
  logic               accept;
  logic               exec;
  logic [3:0]         univ_in;
  logic [CNT_W-1:0]   cnt_in;
  logic [CADDR_W-1:0] ch_raddr;
  logic [UIDX_W-1:0]  tbl_raddr;
  logic               in_range_in;

  assign accept = (state_r == dusa_pkg::ST_IDLE) && start;
  assign exec   = (state_r == dusa_pkg::ST_EXEC);
  assign busy   = exec;

  assign univ_in     = in_item.first_of_frame ? in_item.universe : univ_r;
  assign cnt_in      = in_item.first_of_frame ? '0 : cnt_r;
  assign tbl_raddr   = UIDX_W'(in_item.universe);
  assign in_range_in = 9'(in_item.universe) < 9'(NUM_UNIVERSES);
  assign ch_raddr    = CADDR_W'(UIDX_W'(univ_in)) * CADDR_W'(CHANNELS_PER_UNIVERSE)
                     + CADDR_W'(cnt_in);

  // ---------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------
  logic               tbl_we;
  logic [ENT_W-1:0]   tbl_wdata;
  logic [ENT_W-1:0]   tbl_rdata;
  logic               ch_we;
  logic [7:0]         ch_rdata;

  dusa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_UNIVERSES)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (UIDX_W'(univ_r)),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  dusa_ram #(
    .WIDTH (8),
    .DEPTH (CH_DEPTH)
  ) u_channel_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_addr_r),
    .wdata (req_r.channel_value),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  // ---------------------------------------------------------------------
  // Execute side: arbitrate, read-modify-write, build the result
  // ---------------------------------------------------------------------
  logic [ENT_W-1:0] entry;
  logic [2:0]       e_src;
  logic [7:0]       e_prio;
  logic [31:0]      e_time;
  logic [CNT_W-1:0] e_fill;
  logic [31:0]      age;
  logic             win;
  logic             taken_now;
  logic [CNT_W-1:0] fill_old;
  logic [CNT_W-1:0] fill_new;
  logic [CNT_W-1:0] cnt_inc;
  logic             in_lim;
  logic             wr;
  logic [2:0]       wr_src;
  logic [7:0]       wr_prio;
  logic [31:0]      wr_time;
  logic [7:0]       old_val;
  dusa_pkg::dusa_out_t result;

  // An entry never written reads as the empty reset entry.
  assign entry = tbl_vld_r ? tbl_rdata : '0;
  assign {e_src, e_prio, e_time, e_fill} = entry;

  assign age = req_r.now_ticks - e_time;

  // In range: empty slot, higher priority, or equal priority with same source or stale owner.
  always_comb begin
    win = 1'b0;
    if (in_range_r) begin
      if (e_src == 3'd0) begin
        win = 1'b1;
      end else if (req_r.priority_req > e_prio) begin
        win = 1'b1;
      end else if (req_r.priority_req == e_prio) begin
        win = (req_r.source_id == e_src) || (age >= timeout_r);
      end
    end
  end

  assign taken_now = req_r.first_of_frame ? win : taken_r;
  assign fill_old  = req_r.first_of_frame ? e_fill : fill_r;
  assign wr_src    = req_r.first_of_frame ? req_r.source_id : own_src_r;
  assign wr_prio   = req_r.first_of_frame ? req_r.priority_req : own_prio_r;
  assign wr_time   = req_r.first_of_frame ? req_r.now_ticks : own_time_r;

  assign in_lim  = cnt_r < CNT_W'(CHANNELS_PER_UNIVERSE);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign wr      = exec && taken_now && in_lim;

  // Channels past the fill count were never written and read as zero.
  assign old_val  = (wr && (cnt_r < fill_old)) ? ch_rdata : 8'd0;
  assign fill_new = (wr && (cnt_inc > fill_old)) ? cnt_inc : fill_old;

  assign ch_we     = wr;
  assign tbl_we    = exec && taken_now;
  assign tbl_wdata = {wr_src, wr_prio, wr_time, fill_new};

  always_comb begin
    result.accepted      = wr;
    result.out_universe  = univ_r;
    result.channel_index = in_lim ? 9'(cnt_r) : 9'd0;
    result.old_value     = old_val;
    result.new_value     = wr ? req_r.channel_value : 8'd0;
    result.frame_end     = req_r.last_of_frame;
  end

  // ---------------------------------------------------------------------
  // Control: state machine and frame position
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    taken_nxt = taken_r;
    univ_nxt  = univ_r;
    unique case (state_r)
      dusa_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = dusa_pkg::ST_EXEC;
          cnt_nxt   = cnt_in;
          univ_nxt  = univ_in;
          if (in_item.first_of_frame) begin
            taken_nxt = 1'b0;
          end
        end
      end
      dusa_pkg::ST_EXEC: begin
        state_nxt = dusa_pkg::ST_IDLE;
        // Close the frame on its last item; otherwise advance and saturate.
        if (req_r.last_of_frame) begin
          cnt_nxt   = '0;
          taken_nxt = 1'b0;
        end else begin
          cnt_nxt   = in_lim ? cnt_inc : cnt_r;
          taken_nxt = taken_now;
        end
      end
      default: begin
        state_nxt = dusa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dusa_pkg::ST_IDLE;
      timeout_r    <= dusa_pkg::TIMEOUT_RESET;
      cnt_r        <= '0;
      taken_r      <= 1'b0;
      univ_r       <= 4'd0;
      out_strobe_r <= 1'b0;
      valid_r      <= '{default: 1'b0};
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      taken_r      <= taken_nxt;
      univ_r       <= univ_nxt;
      out_strobe_r <= exec;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (tbl_we) begin
        valid_r[UIDX_W'(univ_r)] <= 1'b1;
      end
    end
  end

  // Payload: request, addresses, held owner entry and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_item;
      ch_addr_r  <= ch_raddr;
      in_range_r <= in_range_in;
      tbl_vld_r  <= in_range_in && valid_r[tbl_raddr];
    end
    if (exec) begin
      own_src_r    <= wr_src;
      own_prio_r   <= wr_prio;
      own_time_r   <= wr_time;
      fill_r       <= fill_new;
      out_result_r <= result;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

`ifndef SYNTHESIS
  // A taken request raises busy for its execute cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  // Each execute cycle yields exactly one result on the next cycle.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_strobe && !busy))
    else $error("execute cycle did not produce a single result");

  // Rejected or dropped channels carry zero levels.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result.accepted) |->
      (out_result.old_value == 8'd0 && out_result.new_value == 8'd0))
    else $error("rejected channel carries a level");

  // A stored channel always lies inside the universe.
  a_index_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.accepted) |->
      (out_result.channel_index < 9'(CHANNELS_PER_UNIVERSE)
       || CHANNELS_PER_UNIVERSE == 512))
    else $error("stored channel index past the universe");
`endif

endmodule

// ===== rtl/dusa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module dusa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
